// ----- src/flex_deadband_square_map_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: assertion macros
// Shared property macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLEX_DEADBAND_SQUARE_MAP_UNIT_DEFINES_SVH
`define FLEX_DEADBAND_SQUARE_MAP_UNIT_DEFINES_SVH

// The consequent must hold when the antecedent holds, in the same cycle.
`define FDSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdsm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FDSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdsm assertion failed");

`endif

// ----- src/fdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: package
// Types and fixed constants shared by the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsm_pkg;

    localparam int FRAC_W     = 16;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = FRAC_W / DIV_STEPS;
    localparam int SAMPLE_W   = 12;

    localparam logic [SAMPLE_W-1:0] REST_RESET = 12'd120;

    typedef struct packed {
        logic valid;
        logic zero;
        logic full;
    } fdsm_ctl_t;

endpackage

`default_nettype wire

// ----- src/fdsm_front.sv -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: front stage
// Clamps the sample, forms the threshold, the range and the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsm_front #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int REST_MARGIN    = 30,
    parameter int VW             = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [fdsm_pkg::SAMPLE_W-1:0]    flex_sample,
    input  wire logic [fdsm_pkg::SAMPLE_W-1:0]    rest_level,
    output fdsm_pkg::fdsm_ctl_t                   ctl_out,
    output logic      [VW-1:0]                    rem_out,
    output logic      [VW-1:0]                    range_out
);

    localparam int XW = (VW > fdsm_pkg::SAMPLE_W) ? VW : fdsm_pkg::SAMPLE_W;
    localparam int SW = XW + 1;

    logic [SW-1:0]       th_sum;
    logic [SW-1:0]       th_cap;
    logic [SW-1:0]       th_wide;
    logic [VW-1:0]       th;
    logic [XW-1:0]       x_ext;
    logic [XW-1:0]       fs_ext;
    logic [XW-1:0]       x_wide;
    logic [VW-1:0]       x;
    logic [VW-1:0]       num;
    logic [VW-1:0]       range;
    logic                zero;
    logic                full;

    fdsm_pkg::fdsm_ctl_t ctl_reg;
    fdsm_pkg::fdsm_ctl_t ctl_next;
    logic [VW-1:0]       rem_reg;
    logic [VW-1:0]       rem_next;
    logic [VW-1:0]       range_reg;

    always_comb
    begin
        th_sum  = SW'(rest_level) + SW'(REST_MARGIN);
        th_cap  = SW'(ADC_FULL_SCALE - 1);
        th_wide = (th_sum > th_cap) ? th_cap : th_sum;
        th      = th_wide[VW-1:0];

        x_ext   = XW'(flex_sample);
        fs_ext  = XW'(ADC_FULL_SCALE);
        x_wide  = (x_ext > fs_ext) ? fs_ext : x_ext;
        x       = x_wide[VW-1:0];

        zero    = (x <= th);
        num     = x - th;
        range   = VW'(ADC_FULL_SCALE) - th;
        full    = !zero && (num == range);

        ctl_next.valid = start;
        ctl_next.zero  = zero;
        ctl_next.full  = full;
        rem_next       = (zero || full) ? '0 : num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        range_reg <= range;
    end

    assign ctl_out   = ctl_reg;
    assign rem_out   = rem_reg;
    assign range_out = range_reg;

endmodule

`default_nettype wire

// ----- src/fdsm_div_stage.sv -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: divider stage
// One register stage of the restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsm_div_stage #(
    parameter int VW = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fdsm_pkg::fdsm_ctl_t            ctl_in,
    input  wire logic [VW-1:0]                  rem_in,
    input  wire logic [VW-1:0]                  range_in,
    input  wire logic [fdsm_pkg::FRAC_W-1:0]    quo_in,
    output fdsm_pkg::fdsm_ctl_t                 ctl_out,
    output logic      [VW-1:0]                  rem_out,
    output logic      [VW-1:0]                  range_out,
    output logic      [fdsm_pkg::FRAC_W-1:0]    quo_out
);

    logic [VW-1:0]                 rem_work;
    logic [VW:0]                   rem_dbl;
    logic [fdsm_pkg::FRAC_W-1:0]   quo_work;

    fdsm_pkg::fdsm_ctl_t           ctl_reg;
    logic [VW-1:0]                 rem_reg;
    logic [VW-1:0]                 range_reg;
    logic [fdsm_pkg::FRAC_W-1:0]   quo_reg;

    // The remainder stays below the range, so each step yields one quotient bit.
    always_comb
    begin
        rem_work = rem_in;
        quo_work = quo_in;
        rem_dbl  = '0;
        for (int i = 0; i < fdsm_pkg::DIV_STEPS; i++)
        begin
            rem_dbl = {rem_work, 1'b0};
            if (rem_dbl >= {1'b0, range_in})
            begin
                rem_dbl  = rem_dbl - {1'b0, range_in};
                quo_work = {quo_work[fdsm_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                quo_work = {quo_work[fdsm_pkg::FRAC_W-2:0], 1'b0};
            end
            rem_work = rem_dbl[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_work;
        range_reg <= range_in;
        quo_reg   <= quo_work;
    end

    assign ctl_out   = ctl_reg;
    assign rem_out   = rem_reg;
    assign range_out = range_reg;
    assign quo_out   = quo_reg;

endmodule

`default_nettype wire

// ----- src/fdsm_square.sv -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: square stage
// Selects the normalized level and registers its square as the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsm_square (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fdsm_pkg::fdsm_ctl_t            ctl_in,
    input  wire logic [fdsm_pkg::FRAC_W-1:0]    quo_in,
    output logic                                done,
    output logic      [fdsm_pkg::FRAC_W-1:0]    bend_level
);

    logic [fdsm_pkg::FRAC_W-1:0]     u;
    logic [2*fdsm_pkg::FRAC_W-1:0]   prod_next;
    logic [2*fdsm_pkg::FRAC_W-1:0]   prod_reg;
    logic                            done_reg;

    always_comb
    begin
        if (ctl_in.zero)
        begin
            u = '0;
        end
        else if (ctl_in.full)
        begin
            u = '1;
        end
        else
        begin
            u = quo_in;
        end
        prod_next = (2*fdsm_pkg::FRAC_W)'(u) * (2*fdsm_pkg::FRAC_W)'(u);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign done       = done_reg;
    assign bend_level = prod_reg[2*fdsm_pkg::FRAC_W-1:fdsm_pkg::FRAC_W];

endmodule

`default_nettype wire

// ----- src/flex_deadband_square_map_unit.sv -----
// The result strobe rises once a sample has passed the front, divider and squaring registers.
// Throughput: one sample per cycle; busy stays low and the pipeline never stalls.
// The six stages are the front stage, four divider stages of four bits each,
// and the squaring multiplier. Reset clears all valid bits and sets rest_level to 120.
// ----------------------------------------------------------------------------
// Flex dead-band square map: top level
// Dead-bands a flex-sensor sample, normalizes it by division and squares it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flex_deadband_square_map_unit_defines.svh"

module flex_deadband_square_map_unit #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int REST_MARGIN    = 30
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [fdsm_pkg::SAMPLE_W-1:0]    flex_sample,
    output logic                                  done,
    output logic      [fdsm_pkg::FRAC_W-1:0]      bend_level,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fdsm_pkg::SAMPLE_W-1:0]    cfg_data
);

    localparam int VW = $clog2(ADC_FULL_SCALE + 1);
    localparam int NS = fdsm_pkg::DIV_STAGES;

    logic [fdsm_pkg::SAMPLE_W-1:0]   rest_level_reg;
    logic [fdsm_pkg::SAMPLE_W-1:0]   rest_level_next;

    fdsm_pkg::fdsm_ctl_t             ctl_pipe   [0:NS];
    logic [VW-1:0]                   rem_pipe   [0:NS];
    logic [VW-1:0]                   range_pipe [0:NS];
    logic [fdsm_pkg::FRAC_W-1:0]     quo_pipe   [0:NS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rest_level_next = (cfg_valid && cfg_ready) ? cfg_data : rest_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_level_reg <= fdsm_pkg::REST_RESET;
        end
        else
        begin
            rest_level_reg <= rest_level_next;
        end
    end

    fdsm_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .REST_MARGIN    (REST_MARGIN),
        .VW             (VW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start && !busy),
        .flex_sample (flex_sample),
        .rest_level  (rest_level_reg),
        .ctl_out     (ctl_pipe[0]),
        .rem_out     (rem_pipe[0]),
        .range_out   (range_pipe[0])
    );

    assign quo_pipe[0] = '0;

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        fdsm_div_stage #(
            .VW (VW)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_pipe[s]),
            .rem_in    (rem_pipe[s]),
            .range_in  (range_pipe[s]),
            .quo_in    (quo_pipe[s]),
            .ctl_out   (ctl_pipe[s+1]),
            .rem_out   (rem_pipe[s+1]),
            .range_out (range_pipe[s+1]),
            .quo_out   (quo_pipe[s+1])
        );
    end

    fdsm_square u_square (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl_pipe[NS]),
        .quo_in     (quo_pipe[NS]),
        .done       (done),
        .bend_level (bend_level)
    );

    `FDSM_ASSERT_IMPL(a_start_gives_done, start && !busy, ##6 done)
    `FDSM_ASSERT_IMPL(a_done_has_start, done, $past(start, 6))
    `FDSM_ASSERT_IMPL(a_deadband_zero, ctl_pipe[0].valid && ctl_pipe[0].zero, ##5 (bend_level == '0))
    `FDSM_ASSERT_IMPL(a_full_scale_top, ctl_pipe[0].valid && ctl_pipe[0].full, ##5 (bend_level == 16'hFFFE))

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Flex dead-band square map: testbench
// Sends flex samples under several rest levels, directed edges first and then
// random values with random gaps, and checks every bend level in order against
// a fixed-point prediction of the dead-band, divide and square.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE = 4095;
    localparam int MARGIN     = 30;
    localparam int LATENCY    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;

    class bend_scoreboard;
        logic [fdsm_pkg::SAMPLE_W-1:0] rest_level;
        logic [fdsm_pkg::FRAC_W-1:0]   levels_due[$];
        int unsigned                   mismatches;

        function new();
            rest_level = fdsm_pkg::REST_RESET;
            mismatches = 0;
        endfunction

        function logic [fdsm_pkg::FRAC_W-1:0] square_level(logic [fdsm_pkg::SAMPLE_W-1:0] s);
            longint unsigned x;
            longint unsigned th;
            longint unsigned span;
            longint unsigned u;
            longint unsigned y;
            x = s;
            if (x > FULL_SCALE)
                x = FULL_SCALE;
            th = longint'(rest_level) + MARGIN;
            if (th > FULL_SCALE - 1)
                th = FULL_SCALE - 1;
            if (x <= th)
                return '0;
            span = FULL_SCALE - th;
            u = ((x - th) << 16) / span;
            if (u > 65535)
                u = 65535;
            y = (u * u) >> 16;
            if (y > 65535)
                y = 65535;
            return y[15:0];
        endfunction

        function void note_sample(logic [fdsm_pkg::SAMPLE_W-1:0] s);
            levels_due.push_back(square_level(s));
        endfunction

        function void check_level(logic [fdsm_pkg::FRAC_W-1:0] got);
            logic [fdsm_pkg::FRAC_W-1:0] want;
            if (levels_due.size() == 0)
            begin
                $error("bend_level: expected none, actual %0d", got);
                mismatches++;
            end
            else
            begin
                want = levels_due.pop_front();
                if (got !== want)
                begin
                    $error("bend_level: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [fdsm_pkg::SAMPLE_W-1:0] flex_sample;
    logic                          done;
    logic [fdsm_pkg::FRAC_W-1:0]   bend_level;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [fdsm_pkg::SAMPLE_W-1:0] cfg_data;

    bend_scoreboard sb;
    int unsigned    cycle_count;
    bit             calm;

    flex_deadband_square_map_unit #(
        .ADC_FULL_SCALE(FULL_SCALE),
        .REST_MARGIN(MARGIN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .flex_sample(flex_sample),
        .done(done),
        .bend_level(bend_level),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_level(bend_level);
    end

    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function logic [fdsm_pkg::SAMPLE_W-1:0] pick_sample();
        int th;
        int v;
        int unsigned r;
        th = int'(sb.rest_level) + MARGIN;
        if (th > FULL_SCALE - 1)
            th = FULL_SCALE - 1;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom_range(0, 4095);
        else if (r < 65)
            v = th + int'($urandom_range(0, 8)) - 4;
        else if (r < 80)
            v = 4095 - int'($urandom_range(0, 6));
        else if (r < 90)
            v = $urandom_range(0, 40);
        else
            v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task send_sample(input logic [fdsm_pkg::SAMPLE_W-1:0] s, input int unsigned gap);
        start <= 1'b1;
        flex_sample <= s;
        do
            @(posedge clk);
        while (busy);
        sb.note_sample(s);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.levels_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    task write_rest(input logic [fdsm_pkg::SAMPLE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.rest_level = v;
    endtask

    task random_phase(input logic [fdsm_pkg::SAMPLE_W-1:0] rest);
        drain();
        write_rest(rest);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_sample(pick_sample(), pick_gap());
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        flex_sample = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(12'd0, 0);
        send_sample(12'd149, 1);
        send_sample(12'd150, 0);
        send_sample(12'd151, 0);
        send_sample(12'd4094, 2);
        send_sample(12'd4095, 0);
        send_sample(12'hAAA, 0);
        send_sample(12'h555, 0);

        drain();
        write_rest(12'd0);
        send_sample(12'd0, 0);
        send_sample(12'd30, 0);
        send_sample(12'd31, 1);
        send_sample(12'd32, 0);
        send_sample(12'd4095, 0);

        drain();
        write_rest(12'd4095);
        send_sample(12'd4093, 0);
        send_sample(12'd4094, 0);
        send_sample(12'd4095, 0);

        drain();
        write_rest(12'd4064);
        send_sample(12'd4093, 0);
        send_sample(12'd4094, 3);
        send_sample(12'd4095, 0);

        random_phase(12'd0);
        random_phase(12'd4095);
        random_phase(fdsm_pkg::REST_RESET);
        random_phase(12'd4065);
        random_phase(12'd1);
        random_phase(12'($urandom_range(0, 4095)));
        random_phase(12'($urandom_range(0, 4095)));

        drain();
        repeat (LATENCY * 2) @(posedge clk);
        if (sb.mismatches == 0 && sb.levels_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
